// ===== rtl/c2a_pkg.sv =====
// shared types and constants for the extradata to annex b header converter
`default_nettype none

package c2a_pkg;

  // lookahead depth and the most words one input byte can cause
  localparam int LA_DEPTH    = 6;
  localparam int BURST_DEPTH = 7;

  // record walker and search phases
  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_SKIP      = 4'd1,
    PH_LENSZ     = 4'd2,
    PH_COUNT     = 4'd3,
    PH_ARR_TYPE  = 4'd4,
    PH_NUM_HI    = 4'd5,
    PH_NUM_LO    = 4'd6,
    PH_LEN_HI    = 4'd7,
    PH_LEN_LO    = 4'd8,
    PH_PAYLOAD   = 4'd9,
    PH_DONE      = 4'd10,
    PH_SCAN      = 4'd11,
    PH_PASS      = 4'd12,
    PH_FAIL      = 4'd13,
    PH_COPY      = 4'd14
  } c2a_phase_t;

  // codec selection codes
  localparam logic [1:0] CODEC_H264 = 2'd0;
  localparam logic [1:0] CODEC_H265 = 2'd1;
  localparam logic [1:0] CODEC_COPY = 2'd2;

  // end-of-header status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_START = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  // word kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // record constants
  localparam logic [7:0]  START_MARK     = 8'h01;
  localparam logic [7:0]  AVC_COUNT_MASK = 8'h1f;
  localparam logic [4:0]  SKIP_AVC       = 5'd3;
  localparam logic [4:0]  SKIP_HVC       = 5'd21 - 5'd1;
  localparam logic [2:0]  LEN_SIZE_RESET = 3'd4;
  localparam logic [19:0] SIZE_MAX       = 20'hFFFFF;

  // one output word
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [2:0]  length_field_bytes;
    logic [19:0] header_size;
    logic        last_result;
  } c2a_item_t;

  // all words caused by one input byte
  typedef struct packed {
    logic [2:0]                        count;
    c2a_item_t [BURST_DEPTH-1:0]       items;
  } c2a_burst_t;

endpackage

`default_nettype wire

// ===== rtl/c2a_parse.sv =====
// record walker and start code search: state and the word burst for each byte
`default_nettype none

module c2a_parse import c2a_pkg::*; #(
  parameter int SCAN_WINDOW = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic [1:0] codec_standard,
  output c2a_burst_t      burst
);

  localparam int NEED = (SCAN_WINDOW + 2 > 4) ? SCAN_WINDOW + 2 : 4;

  typedef struct packed {
    c2a_phase_t  phase;
    logic        second;
    logic [7:0]  arrays;
  } unit_t;

  // registers
  c2a_phase_t  phase, phase_next;
  logic [1:0]  std_cur, std_cur_next;
  logic [4:0]  skip_count, skip_count_next;
  logic [15:0] nal_bytes_left, nal_bytes_left_next;
  logic [15:0] nalus_left, nalus_left_next;
  logic [7:0]  arrays_left, arrays_left_next;
  logic        in_second_set, in_second_set_next;
  logic [2:0]  length_size, length_size_next;
  logic [19:0] emitted_count, emitted_count_next;
  logic [2:0]  lookahead_fill, lookahead_fill_next;
  logic        held_valid, held_valid_next;
  logic [7:0]  held_data, held_data_next;
  logic [7:0]  lookahead [LA_DEPTH];

  // working signals
  logic [7:0]  la_new [LA_DEPTH];
  logic [7:0]  dlist [LA_DEPTH];
  logic [2:0]  nd;
  logic        end_v;
  logic [1:0]  end_st;
  logic        la_wr;
  logic [20:0] cnt_sum;

  // step to the next nal unit, set or array
  function automatic unit_t next_unit(input logic [15:0] nalus, input logic [1:0] std,
                                      input logic second, input logic [7:0] arrays);
    unit_t u;
    u.phase  = PH_DONE;
    u.second = second;
    u.arrays = arrays;
    if (nalus != 16'd0) begin
      u.phase = PH_LEN_HI;
    end else if (std == CODEC_H264) begin
      if (!second) begin
        u.second = 1'b1;
        u.phase  = PH_COUNT;
      end
    end else if (arrays != 8'd0) begin
      u.arrays = arrays - 8'd1;
      u.phase  = PH_ARR_TYPE;
    end
    return u;
  endfunction

  // lookahead with this byte written at the fill position
  always_comb begin
    for (int i = 0; i < LA_DEPTH; i++) begin
      la_new[i] = (3'(i) == lookahead_fill) ? in_byte : lookahead[i];
    end
  end

  // next state and burst contents
  always_comb begin
    logic       handled;
    logic       walker;
    logic       match;
    logic [2:0] n;
    logic [7:0] tail;
    logic [4:0] skip_tmp;
    unit_t      u;
    c2a_phase_t ph;

    std_cur_next        = std_cur;
    skip_count_next     = skip_count;
    nal_bytes_left_next = nal_bytes_left;
    nalus_left_next     = nalus_left;
    arrays_left_next    = arrays_left;
    in_second_set_next  = in_second_set;
    length_size_next    = length_size;
    lookahead_fill_next = lookahead_fill;
    held_valid_next     = held_valid;
    held_data_next      = held_data;
    la_wr    = 1'b0;
    nd       = 3'd0;
    end_v    = 1'b0;
    end_st   = ST_OK;
    handled  = 1'b0;
    walker   = 1'b0;
    match    = 1'b0;
    skip_tmp = 5'd0;
    u        = '0;
    for (int i = 0; i < LA_DEPTH; i++) begin
      dlist[i] = la_new[i];
    end
    n    = (lookahead_fill < 3'(LA_DEPTH)) ? lookahead_fill + 3'd1 : 3'(LA_DEPTH);
    tail = la_new[n - 3'd1];
    ph   = phase;

    // first byte of a record picks the codec and the record form
    if (phase == PH_START) begin
      std_cur_next = (codec_standard > CODEC_H265) ? CODEC_COPY : codec_standard;
      if (std_cur_next == CODEC_COPY) begin
        ph = PH_COPY;
      end else if (in_byte == START_MARK) begin
        handled = 1'b1;
        if (in_last) begin
          end_v  = 1'b1;
          end_st = ST_SHORT;
        end else begin
          ph              = PH_SKIP;
          skip_count_next = (std_cur_next == CODEC_H264) ? SKIP_AVC : SKIP_HVC;
        end
      end else begin
        ph = PH_SCAN;
      end
    end

    if (!handled) begin
      case (ph)
        PH_COPY: begin
          dlist[0] = in_byte;
          nd       = 3'd1;
          if (in_last) begin
            end_v = 1'b1;
          end
        end
        PH_SCAN: begin
          la_wr               = 1'b1;
          lookahead_fill_next = n;
          for (int k = 0; k < SCAN_WINDOW; k++) begin
            if (3'(k + 2) < n && la_new[k] == 8'h00 && la_new[k+1] == 8'h00 &&
                la_new[k+2] == START_MARK) begin
              match = 1'b1;
            end
          end
          if (n >= 3'd4 && match) begin
            nd = n;
            if (std_cur_next == CODEC_H264) begin
              if (in_last) begin
                if (tail == 8'h00) begin
                  nd = n - 3'd1;
                end
              end else begin
                nd              = n - 3'd1;
                held_valid_next = 1'b1;
                held_data_next  = tail;
              end
            end
            ph = PH_PASS;
            if (in_last) begin
              end_v = 1'b1;
            end
          end else if (in_last) begin
            end_v  = 1'b1;
            end_st = (n <= 3'd3) ? ST_SHORT : ST_NO_START;
          end else if (n >= 3'(NEED)) begin
            ph = PH_FAIL;
          end
        end
        PH_PASS: begin
          if (std_cur_next == CODEC_H264) begin
            dlist[0] = held_valid ? held_data : in_byte;
            dlist[1] = in_byte;
            nd = {2'b00, held_valid} + {2'b00, in_last && in_byte != 8'h00};
            held_valid_next = !in_last;
            held_data_next  = in_byte;
          end else begin
            dlist[0] = in_byte;
            nd       = 3'd1;
          end
          if (in_last) begin
            end_v = 1'b1;
          end
        end
        PH_FAIL: begin
          if (in_last) begin
            end_v  = 1'b1;
            end_st = ST_NO_START;
          end
        end
        PH_SKIP: begin
          walker   = 1'b1;
          skip_tmp = (skip_count != 5'd0) ? skip_count - 5'd1 : skip_count;
          skip_count_next = skip_tmp;
          if (skip_tmp == 5'd0) begin
            ph = PH_LENSZ;
          end
        end
        PH_LENSZ: begin
          walker           = 1'b1;
          length_size_next = {1'b0, in_byte[1:0]} + 3'd1;
          ph               = PH_COUNT;
        end
        PH_COUNT: begin
          walker = 1'b1;
          if (std_cur_next == CODEC_H264) begin
            nalus_left_next = in_second_set ? {8'h00, in_byte}
                                            : {8'h00, in_byte & AVC_COUNT_MASK};
          end else begin
            arrays_left_next = in_byte;
            nalus_left_next  = 16'd0;
          end
          u = next_unit(nalus_left_next, std_cur_next, in_second_set, arrays_left_next);
          ph                 = u.phase;
          in_second_set_next = u.second;
          arrays_left_next   = u.arrays;
        end
        PH_ARR_TYPE: begin
          walker = 1'b1;
          ph     = PH_NUM_HI;
        end
        PH_NUM_HI: begin
          walker          = 1'b1;
          nalus_left_next = {in_byte, 8'h00};
          ph              = PH_NUM_LO;
        end
        PH_NUM_LO: begin
          walker          = 1'b1;
          nalus_left_next = nalus_left | {8'h00, in_byte};
          u = next_unit(nalus_left_next, std_cur_next, in_second_set, arrays_left);
          ph                 = u.phase;
          in_second_set_next = u.second;
          arrays_left_next   = u.arrays;
        end
        PH_LEN_HI: begin
          walker              = 1'b1;
          nal_bytes_left_next = {in_byte, 8'h00};
          ph                  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          walker              = 1'b1;
          nal_bytes_left_next = nal_bytes_left | {8'h00, in_byte};
          nalus_left_next     = nalus_left - 16'd1;
          dlist[0] = 8'h00;
          dlist[1] = 8'h00;
          dlist[2] = 8'h00;
          dlist[3] = START_MARK;
          nd       = 3'd4;
          if (nal_bytes_left_next != 16'd0) begin
            ph = PH_PAYLOAD;
          end else begin
            u = next_unit(nalus_left_next, std_cur_next, in_second_set, arrays_left);
            ph                 = u.phase;
            in_second_set_next = u.second;
            arrays_left_next   = u.arrays;
          end
        end
        PH_PAYLOAD: begin
          walker              = 1'b1;
          dlist[0]            = in_byte;
          nd                  = 3'd1;
          nal_bytes_left_next = nal_bytes_left - 16'd1;
          if (nal_bytes_left_next == 16'd0) begin
            u = next_unit(nalus_left, std_cur_next, in_second_set, arrays_left);
            ph                 = u.phase;
            in_second_set_next = u.second;
            arrays_left_next   = u.arrays;
          end
        end
        default: begin
          walker = 1'b1;
        end
      endcase

      // record walker closes with ok only when the record was complete
      if (walker && in_last) begin
        end_v  = 1'b1;
        end_st = (ph == PH_DONE) ? ST_OK : ST_TRUNC;
      end
    end

    phase_next = ph;

    // saturating count of emitted bytes
    cnt_sum            = {1'b0, emitted_count} + {18'd0, nd};
    emitted_count_next = cnt_sum[20] ? SIZE_MAX : cnt_sum[19:0];

    // burst of words for this byte
    burst.count = nd + {2'b00, end_v};
    burst.items = '0;
    for (int i = 0; i < LA_DEPTH; i++) begin
      if (3'(i) < nd) begin
        burst.items[i].item_kind          = KIND_DATA;
        burst.items[i].data_byte          = dlist[i];
        burst.items[i].length_field_bytes = length_size_next;
      end
    end
    if (end_v) begin
      burst.items[nd].item_kind          = KIND_END;
      burst.items[nd].status             = end_st;
      burst.items[nd].length_field_bytes = length_size_next;
      burst.items[nd].header_size        =
        (end_st == ST_NO_START || end_st == ST_SHORT) ? 20'd0 : emitted_count_next;
    end
    if (burst.count != 3'd0) begin
      burst.items[burst.count - 3'd1].last_result = 1'b1;
    end

    // the final byte of a record returns everything to the start
    if (in_last) begin
      phase_next          = PH_START;
      skip_count_next     = 5'd0;
      nal_bytes_left_next = 16'd0;
      nalus_left_next     = 16'd0;
      arrays_left_next    = 8'd0;
      in_second_set_next  = 1'b0;
      length_size_next    = LEN_SIZE_RESET;
      emitted_count_next  = 20'd0;
      lookahead_fill_next = 3'd0;
      held_valid_next     = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      std_cur        <= CODEC_H264;
      skip_count     <= 5'd0;
      nal_bytes_left <= 16'd0;
      nalus_left     <= 16'd0;
      arrays_left    <= 8'd0;
      in_second_set  <= 1'b0;
      length_size    <= LEN_SIZE_RESET;
      emitted_count  <= 20'd0;
      lookahead_fill <= 3'd0;
      held_valid     <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      std_cur        <= std_cur_next;
      skip_count     <= skip_count_next;
      nal_bytes_left <= nal_bytes_left_next;
      nalus_left     <= nalus_left_next;
      arrays_left    <= arrays_left_next;
      in_second_set  <= in_second_set_next;
      length_size    <= length_size_next;
      emitted_count  <= emitted_count_next;
      lookahead_fill <= lookahead_fill_next;
      held_valid     <= held_valid_next;
    end
  end

  // payload registers: held byte and lookahead window
  always_ff @(posedge clk) begin
    if (accept) begin
      held_data <= held_data_next;
      if (la_wr) begin
        lookahead <= la_new;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/c2a_burst.sv =====
// burst buffer and output register: hands out one word per cycle while the receiver is ready
`default_nettype none

module c2a_burst import c2a_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire c2a_burst_t burst,
  output logic            out_valid,
  input  wire logic       out_ready,
  output c2a_item_t       out_item
);

  logic [2:0]                  count;
  c2a_item_t [BURST_DEPTH-1:0] items;
  logic                        out_free;
  logic                        move;
  logic                        load;

  // handshake: a new burst may enter once the buffer drains this cycle
  assign out_free = !out_valid || out_ready;
  assign move     = out_free && (count != 3'd0);
  assign in_ready = (count == 3'd0) || (count == 3'd1 && out_free);
  assign load     = in_valid && in_ready;

  // word count of the buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else if (load) begin
      count <= burst.count;
    end else if (move) begin
      count <= count - 3'd1;
    end
  end

  // buffer contents: load a burst or shift toward the head
  always_ff @(posedge clk) begin
    if (load) begin
      items <= burst.items;
    end else if (move) begin
      for (int i = 0; i < BURST_DEPTH - 1; i++) begin
        items[i] <= items[i+1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= move;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_item <= items[0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/codec_header_to_annexb.sv =====
// top level of the extradata to annex b header converter
// Usage:
//   Extradata enters one byte per word on the in channel (in_byte, in_last
//   marks the final byte). Header words leave on the out channel: data words
//   carry a header byte, and the step with in_last adds one end word with the
//   status, length field size and header size. A byte causes zero to seven
//   words; each word carries last_result on the final word of its byte.
//   The cfg channel writes codec_standard (always ready); it is sampled on
//   the first byte of each record.
// Timing: the words of a byte pass through the burst buffer and then the output
//   register. All the work for a byte is done in the cycle it is taken.
// Throughput: one word per cycle on the out side while the receiver is ready; a
//   byte that causes k words holds the in side until the burst buffer has drained
//   through the single output register. Bytes causing one word or none flow at one
//   per cycle while the receiver is ready.
// Reset: synchronous, returns to the start of a record with codec H.264 and
//   an empty buffer. A stalled receiver holds the output register; the
//   buffer behind it then fills and in_ready drops.
`default_nettype none

module codec_header_to_annexb import c2a_pkg::*; #(
  parameter int SCAN_WINDOW = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             item_kind,
  output logic [7:0]       data_byte,
  output logic [1:0]       status,
  output logic [2:0]       length_field_bytes,
  output logic [19:0]      header_size,
  output logic             last_result
);

  logic [1:0] codec_standard;
  c2a_burst_t burst;
  c2a_item_t  out_item;
  logic       accept;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_standard <= CODEC_H264;
    end else if (cfg_valid && cfg_ready) begin
      codec_standard <= cfg_data;
    end
  end

  assign accept = in_valid && in_ready;

  // record parsing
  c2a_parse #(
    .SCAN_WINDOW(SCAN_WINDOW)
  ) u_parse (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .codec_standard (codec_standard),
    .burst          (burst)
  );

  // word buffer and output register
  c2a_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .burst     (burst),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // output fields
  assign item_kind          = out_item.item_kind;
  assign data_byte          = out_item.data_byte;
  assign status             = out_item.status;
  assign length_field_bytes = out_item.length_field_bytes;
  assign header_size        = out_item.header_size;
  assign last_result        = out_item.last_result;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// testbench for the extradata to annex b header converter: directed table, then random records
`timescale 1ns / 100ps

module tb_top;
  import c2a_pkg::*;

  localparam int SCAN_WIN      = 4;
  localparam int SCAN_NEED     = (SCAN_WIN + 2 > 4) ? SCAN_WIN + 2 : 4;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 20;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int DIR_ROWS      = 28;

  // directed table row kinds
  typedef enum logic [1:0] {
    OP_CFG,
    OP_BYTE,
    OP_BYTE_END
  } dir_op_t;

  typedef struct packed {
    dir_op_t    op;
    logic [7:0] val;
    logic       last;
    logic [1:0] st;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = CODEC_H264;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        item_kind;
  logic [7:0]  data_byte;
  logic [1:0]  status;
  logic [2:0]  length_field_bytes;
  logic [19:0] header_size;
  logic        last_result;

  int          send_idle_pct = 37;
  int          recv_idle_pct = 87;
  int          fail_count = 0;
  int unsigned cycle_n = 0;

  // header words still to come out of the block, oldest first
  c2a_item_t   hdr_words_q [$];
  c2a_item_t   step_words [$];
  logic [7:0]  rec_q [$];
  dir_row_t    dir_tab [DIR_ROWS];

  // predictor state
  logic [1:0]  codec_reg;
  logic [1:0]  rec_codec;
  c2a_phase_t  ph;
  logic [4:0]  skip_left;
  logic [15:0] nal_left;
  logic [15:0] units_left;
  logic [7:0]  arrays_left;
  logic        second_set;
  logic [2:0]  len_size;
  logic [19:0] emitted;
  logic [7:0]  la [LA_DEPTH];
  int          la_fill;
  logic [8:0]  held;

  codec_header_to_annexb #(.SCAN_WINDOW(SCAN_WIN)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .item_kind(item_kind),
    .data_byte(data_byte),
    .status(status),
    .length_field_bytes(length_field_bytes),
    .header_size(header_size),
    .last_result(last_result)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // record state back to the start of a record
  function automatic void clear_rec();
    ph = PH_START;
    skip_left = '0;
    nal_left = '0;
    units_left = '0;
    arrays_left = '0;
    second_set = 1'b0;
    len_size = LEN_SIZE_RESET;
    emitted = '0;
    for (int i = 0; i < LA_DEPTH; i++) la[i] = 8'h00;
    la_fill = 0;
    held = '0;
  endfunction

  function automatic void put_word(logic k, logic [7:0] b, logic [1:0] st, logic [19:0] sz);
    c2a_item_t w;
    w.item_kind = k;
    w.data_byte = b;
    w.status = st;
    w.length_field_bytes = len_size;
    w.header_size = sz;
    w.last_result = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    put_word(KIND_DATA, b, ST_OK, '0);
    if (emitted != SIZE_MAX) emitted++;
  endfunction

  function automatic void emit_end(logic [1:0] st);
    put_word(KIND_END, 8'h00, st, (st == ST_NO_START || st == ST_SHORT) ? 20'd0 : emitted);
  endfunction

  // move on to the next nal unit, parameter set or array
  function automatic void next_unit();
    if (units_left != 0) begin
      ph = PH_LEN_HI;
    end else if (rec_codec == CODEC_H264) begin
      if (!second_set) begin
        second_set = 1'b1;
        ph = PH_COUNT;
      end else begin
        ph = PH_DONE;
      end
    end else if (arrays_left != 0) begin
      arrays_left--;
      ph = PH_ARR_TYPE;
    end else begin
      ph = PH_DONE;
    end
  endfunction

  // 00 00 01 at one of the first scan positions
  function automatic bit start_code_seen(int n);
    for (int k = 0; k < SCAN_WIN && k + 2 < n && k + 2 < LA_DEPTH; k++) begin
      if (la[k] == 8'h00 && la[k+1] == 8'h00 && la[k+2] == START_MARK) return 1'b1;
    end
    return 1'b0;
  endfunction

  // release buffered bytes; h.264 holds back the newest one
  function automatic void flush_la(int n, logic last);
    for (int i = 0; i < n && i < LA_DEPTH; i++) begin
      if (i + 1 == n && rec_codec == CODEC_H264) begin
        if (last) begin
          if (la[i] != 8'h00) emit_byte(la[i]);
        end else begin
          held = {1'b1, la[i]};
        end
      end else begin
        emit_byte(la[i]);
      end
    end
  endfunction

  // header words caused by one extradata byte
  function automatic void annexb_predict(input logic [7:0] b, input logic last,
                                         output bit ignored);
    bit taken;
    int n;
    c2a_item_t w;
    step_words.delete();
    taken = 1'b0;
    ignored = !last && (ph == PH_DONE || ph == PH_FAIL);
    if (ph == PH_START) begin
      rec_codec = (codec_reg > CODEC_H265) ? CODEC_COPY : codec_reg;
      if (rec_codec == CODEC_COPY) begin
        ph = PH_COPY;
      end else if (b == START_MARK) begin
        taken = 1'b1;
        if (last) begin
          emit_end(ST_SHORT);
        end else begin
          ph = PH_SKIP;
          skip_left = (rec_codec == CODEC_H264) ? SKIP_AVC : SKIP_HVC;
        end
      end else begin
        ph = PH_SCAN;
      end
    end
    if (!taken) begin
      case (ph)
        PH_COPY: begin
          emit_byte(b);
          if (last) emit_end(ST_OK);
        end
        PH_SCAN: begin
          if (la_fill < LA_DEPTH) begin
            la[la_fill] = b;
            la_fill++;
          end
          n = la_fill;
          if (n >= 4 && start_code_seen(n)) begin
            flush_la(n, last);
            ph = PH_PASS;
            if (last) emit_end(ST_OK);
          end else if (last) begin
            emit_end((n <= 3) ? ST_SHORT : ST_NO_START);
          end else if (n >= SCAN_NEED) begin
            ph = PH_FAIL;
          end
        end
        PH_PASS: begin
          if (rec_codec == CODEC_H264) begin
            if (held[8]) emit_byte(held[7:0]);
            held = '0;
            if (last) begin
              if (b != 8'h00) emit_byte(b);
            end else begin
              held = {1'b1, b};
            end
          end else begin
            emit_byte(b);
          end
          if (last) emit_end(ST_OK);
        end
        PH_FAIL: begin
          if (last) emit_end(ST_NO_START);
        end
        default: begin
          // record walker
          case (ph)
            PH_SKIP: begin
              if (skip_left != 0) skip_left--;
              if (skip_left == 0) ph = PH_LENSZ;
            end
            PH_LENSZ: begin
              len_size = {1'b0, b[1:0]} + 3'd1;
              ph = PH_COUNT;
            end
            PH_COUNT: begin
              if (rec_codec == CODEC_H264) begin
                units_left = second_set ? {8'h00, b} : {8'h00, b & AVC_COUNT_MASK};
              end else begin
                arrays_left = b;
                units_left = '0;
              end
              next_unit();
            end
            PH_ARR_TYPE: ph = PH_NUM_HI;
            PH_NUM_HI: begin
              units_left = {b, 8'h00};
              ph = PH_NUM_LO;
            end
            PH_NUM_LO: begin
              units_left[7:0] = b;
              next_unit();
            end
            PH_LEN_HI: begin
              nal_left = {b, 8'h00};
              ph = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              nal_left[7:0] = b;
              units_left--;
              emit_byte(8'h00);
              emit_byte(8'h00);
              emit_byte(8'h00);
              emit_byte(START_MARK);
              if (nal_left != 0) ph = PH_PAYLOAD;
              else next_unit();
            end
            PH_PAYLOAD: begin
              emit_byte(b);
              nal_left--;
              if (nal_left == 0) next_unit();
            end
            default: ;
          endcase
          if (last) emit_end((ph == PH_DONE) ? ST_OK : ST_TRUNC);
        end
      endcase
    end
    if (step_words.size() > 0) begin
      w = step_words.pop_back();
      w.last_result = 1'b1;
      step_words.push_back(w);
    end
    if (last) clear_rec();
  endfunction

  function automatic dir_row_t drow(dir_op_t op, logic [7:0] val, logic last, logic [1:0] st);
    dir_row_t r;
    r.op = op;
    r.val = val;
    r.last = last;
    r.st = st;
    return r;
  endfunction

  // random byte with extra weight on the start code bytes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return START_MARK;
      default: return 8'($urandom);
    endcase
  endfunction

  // drive one byte, wait for the word to be taken, queue its header words
  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input logic [1:0] st, output bit ignored);
    c2a_item_t w;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = b;
    in_last = last;
    do @(posedge clk); while (!in_ready);
    annexb_predict(b, last, ignored);
    if (typed) begin
      w.item_kind = KIND_END;
      w.data_byte = 8'h00;
      w.status = st;
      w.length_field_bytes = LEN_SIZE_RESET;
      w.header_size = '0;
      w.last_result = 1'b1;
      hdr_words_q.push_back(w);
    end else begin
      foreach (step_words[i]) hdr_words_q.push_back(step_words[i]);
    end
  endtask

  // let every expected word arrive, then give the pipeline time to settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (hdr_words_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_codec(input logic [1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    codec_reg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // 16-bit nal length then payload
  task automatic add_nal();
    int len;
    len = $urandom_range(0, 4);
    rec_q.push_back(8'h00);
    rec_q.push_back(8'(len));
    repeat (len) rec_q.push_back(pick_byte());
  endtask

  task automatic make_avc();
    int nsets;
    rec_q.push_back(START_MARK);
    repeat (3) rec_q.push_back(pick_byte());
    rec_q.push_back(8'($urandom));
    nsets = $urandom_range(0, 2);
    rec_q.push_back({3'($urandom), 5'(nsets)});
    repeat (nsets) add_nal();
    nsets = $urandom_range(0, 2);
    rec_q.push_back(8'(nsets));
    repeat (nsets) add_nal();
    repeat ($urandom_range(0, 2)) rec_q.push_back(pick_byte());
  endtask

  task automatic make_hvc();
    int narr;
    int nnal;
    rec_q.push_back(START_MARK);
    repeat (20) rec_q.push_back(pick_byte());
    rec_q.push_back(8'($urandom));
    narr = $urandom_range(0, 2);
    rec_q.push_back(8'(narr));
    repeat (narr) begin
      rec_q.push_back(pick_byte());
      nnal = $urandom_range(0, 2);
      rec_q.push_back(8'h00);
      rec_q.push_back(8'(nnal));
      repeat (nnal) add_nal();
    end
    repeat ($urandom_range(0, 2)) rec_q.push_back(pick_byte());
  endtask

  // plain data, start code placed at a scan position or left out
  task automatic make_plain();
    int len;
    int at;
    len = $urandom_range(1, 10);
    repeat (len) rec_q.push_back(pick_byte());
    if (rec_q[0] == START_MARK) rec_q[0] = 8'h00;
    at = $urandom_range(0, 4);
    if (at < 4 && at + 3 <= len) begin
      rec_q[at] = 8'h00;
      rec_q[at+1] = 8'h00;
      rec_q[at+2] = START_MARK;
    end
    if ($urandom_range(0, 2) == 0) rec_q[len-1] = 8'h00;
  endtask

  task automatic send_record(output int counted);
    bit ign;
    counted = 0;
    foreach (rec_q[i]) begin
      send_byte(rec_q[i], i == rec_q.size() - 1, 1'b0, ST_OK, ign);
      if (!ign) counted++;
    end
    rec_q.delete();
  endtask

  // receiver stalls
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // compare each taken word with the oldest expectation
  c2a_item_t got_w;
  c2a_item_t want_w;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_w = {item_kind, data_byte, status, length_field_bytes, header_size, last_result};
      if (hdr_words_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("cycle %0d: unexpected word kind %0d byte %02h st %0d", cycle_n,
                   got_w.item_kind, got_w.data_byte, got_w.status);
      end else begin
        want_w = hdr_words_q.pop_front();
        if (got_w !== want_w) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("cycle %0d: want kind %0d byte %02h st %0d lfb %0d size %0d last %0d",
                     cycle_n, want_w.item_kind, want_w.data_byte, want_w.status,
                     want_w.length_field_bytes, want_w.header_size, want_w.last_result);
            $display("cycle %0d: got  kind %0d byte %02h st %0d lfb %0d size %0d last %0d",
                     cycle_n, got_w.item_kind, got_w.data_byte, got_w.status,
                     got_w.length_field_bytes, got_w.header_size, got_w.last_result);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > LIMIT_CYCLES) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin : stimulus
    int counted;
    int got;
    int quota;
    int pick;
    bit broken;
    bit ign;
    clear_rec();
    codec_reg = CODEC_H264;
    rec_codec = CODEC_H264;
    dir_tab = '{
      // lone start byte right after reset
      drow(OP_BYTE_END, START_MARK, 1'b1, ST_SHORT),
      // short plain data
      drow(OP_BYTE,     8'h00,      1'b0, ST_OK),
      drow(OP_BYTE_END, START_MARK, 1'b1, ST_SHORT),
      // avcc with one sps, length size 1, no pps, one byte past the end
      drow(OP_BYTE,     START_MARK, 1'b0, ST_OK),
      drow(OP_BYTE,     8'hff,      1'b0, ST_OK),
      drow(OP_BYTE,     8'hff,      1'b0, ST_OK),
      drow(OP_BYTE,     8'hff,      1'b0, ST_OK),
      drow(OP_BYTE,     8'hfc,      1'b0, ST_OK),
      drow(OP_BYTE,     8'he1,      1'b0, ST_OK),
      drow(OP_BYTE,     8'h00,      1'b0, ST_OK),
      drow(OP_BYTE,     8'h01,      1'b0, ST_OK),
      drow(OP_BYTE,     8'haa,      1'b0, ST_OK),
      drow(OP_BYTE,     8'h00,      1'b0, ST_OK),
      drow(OP_BYTE,     8'h77,      1'b1, ST_OK),
      // start code found, trailing zero dropped
      drow(OP_BYTE,     8'h00,      1'b0, ST_OK),
      drow(OP_BYTE,     8'h00,      1'b0, ST_OK),
      drow(OP_BYTE,     START_MARK, 1'b0, ST_OK),
      drow(OP_BYTE,     8'h65,      1'b0, ST_OK),
      drow(OP_BYTE,     8'h00,      1'b1, ST_OK),
      // hvcc cut off during the skip bytes
      drow(OP_CFG,      8'(CODEC_H265), 1'b0, ST_OK),
      drow(OP_BYTE,     START_MARK, 1'b0, ST_OK),
      drow(OP_BYTE_END, 8'h00,      1'b1, ST_TRUNC),
      // no start code in the window
      drow(OP_BYTE,     8'h11,      1'b0, ST_OK),
      drow(OP_BYTE,     8'h22,      1'b0, ST_OK),
      drow(OP_BYTE,     8'h33,      1'b0, ST_OK),
      drow(OP_BYTE_END, 8'h44,      1'b1, ST_NO_START),
      // codec value three copies
      drow(OP_CFG,      8'h03,      1'b0, ST_OK),
      drow(OP_BYTE,     8'hff,      1'b1, ST_OK)
    };

    // reset
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == OP_CFG)
        write_codec(dir_tab[i].val[1:0]);
      else
        send_byte(dir_tab[i].val, dir_tab[i].last, dir_tab[i].op == OP_BYTE_END,
                  dir_tab[i].st, ign);
    end

    // random records: three stall profiles, every codec setting in each
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 87 : 0;
      recv_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 37 : 0;
      for (int c = 0; c < 4; c++) begin
        write_codec(c[1:0]);
        quota = (c == CODEC_H265) ? 56 : (c == CODEC_H264) ? 36 : 8;
        counted = 0;
        while (counted < quota) begin
          pick = $urandom_range(0, 9);
          broken = ($urandom_range(0, 3) == 0);
          if ((c == CODEC_H264 && pick < 6) || (c >= CODEC_COPY && pick < 2)) begin
            make_avc();
          end else if ((c == CODEC_H265 && pick < 6) || (c >= CODEC_COPY && pick < 3)) begin
            make_hvc();
          end else if (pick < 9) begin
            make_plain();
            broken = 1'b0;
          end else begin
            repeat ($urandom_range(1, 8)) rec_q.push_back(pick_byte());
            broken = 1'b0;
          end
          // broken records stop at a random byte
          if (broken && rec_q.size() > 1) begin
            got = $urandom_range(1, rec_q.size() - 1);
            while (rec_q.size() > got) rec_q.pop_back();
          end
          send_record(got);
          counted += got;
        end
      end
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
